>>> hw/rtl/m3c_pkg.sv
// Shared types and constants of the masked 3x3 convolution core.
// No dependencies; used by m3c_mac and masked_3x3_convolution_core.
package m3c_pkg;

  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int WGT_FRAC_BITS_DEF   = 12;
  localparam int KERNEL_SIZE         = 3;
  localparam int WGT_W               = 16;            // one packed kernel weight
  localparam int KROW_W              = KERNEL_SIZE * WGT_W;
  localparam int DEN_W               = WGT_W + 4;     // sum of nine weights
  localparam int OUT_W               = 40;
  localparam int CFG_IDX_W           = 2;
  localparam int CFG_DATA_W          = KROW_W;

  // Reset kernel: 0.5 1.0 0.5 / 1.0 -6.0 1.0 / 0.5 1.0 0.5 in Q4.12
  localparam logic [KROW_W-1:0] KROW_OUTER_RST  = 48'h0800_1000_0800;
  localparam logic [KROW_W-1:0] KROW_MIDDLE_RST = 48'h1000_A000_1000;
  localparam logic              ABS_MODE_RST    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KTOP = 2'd0,
    CFG_KMID = 2'd1,
    CFG_KBOT = 2'd2,
    CFG_ABS  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PIX_VALID     = 2'd0,
    PIX_NODATA    = 2'd1,
    PIX_ZERO_WSUM = 2'd2,
    PIX_RSVD      = 2'd3
  } pix_status_e;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic clr;   // clear both accumulators
    logic en;    // issue one tap
    logic vld;   // the issued tap is a valid neighbour
  } mac_ctl_t;

endpackage

>>> hw/rtl/m3c_mac.sv
// Shared multiply-accumulate unit: one kernel tap per cycle, product registered.
// Depends on m3c_pkg (mac_ctl_t, widths).
module m3c_mac #(
  parameter int SAMPLE_BITS = m3c_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_W       = SAMPLE_BITS + m3c_pkg::WGT_W + 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  m3c_pkg::mac_ctl_t                 ctl_i,
  input  logic signed [SAMPLE_BITS-1:0]     sample_i,
  input  logic signed [m3c_pkg::WGT_W-1:0]  weight_i,
  output logic signed [ACC_W-1:0]           num_o,
  output logic signed [m3c_pkg::DEN_W-1:0]  den_o
);

  localparam int PROD_W = SAMPLE_BITS + m3c_pkg::WGT_W;

  logic signed [PROD_W-1:0]          prod_q;
  logic signed [m3c_pkg::WGT_W-1:0]  wgt_q;
  logic                              pv_q;
  logic signed [ACC_W-1:0]           num_q;
  logic signed [m3c_pkg::DEN_W-1:0]  den_q;

  always_ff @(posedge clk_i) begin
    prod_q <= sample_i * weight_i;
    wgt_q  <= weight_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      num_q <= '0;
      den_q <= '0;
    end else if (ctl_i.clr) begin
      pv_q  <= 1'b0;
      num_q <= '0;
      den_q <= '0;
    end else begin
      pv_q <= ctl_i.en & ctl_i.vld;
      // accumulate the tap issued last cycle
      if (pv_q) begin
        num_q <= num_q + ACC_W'(prod_q);
        den_q <= den_q + m3c_pkg::DEN_W'(wgt_q);
      end
    end
  end

  assign num_o = num_q;
  assign den_o = den_q;

endmodule

>>> hw/rtl/m3c_div.sv
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Depends on nothing outside this file; quotient holds after done.
module m3c_div #(
  parameter int DVD_W = 48,
  parameter int DVS_W = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [DVD_W-1:0]                     dividend_i,
  input  logic [DVS_W-1:0]                     divisor_i,
  output logic                                 done_o,
  output logic [2*((DVD_W+1)/2)-1:0]           quot_o
);

  localparam int ITER  = (DVD_W + 1) / 2;
  localparam int P_W   = 2 * ITER;
  localparam int CNT_W = $clog2(ITER + 1);

  logic [P_W-1:0]   acc_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DVS_W:0]   t1, t2;
  logic             ge1, ge2;
  logic [DVS_W-1:0] r1, r2;

  always_comb begin
    t1  = {rem_q, acc_q[P_W-1]};
    ge1 = t1 >= {1'b0, dvs_q};
    r1  = ge1 ? DVS_W'(t1 - {1'b0, dvs_q}) : DVS_W'(t1);
    t2  = {r1, acc_q[P_W-2]};
    ge2 = t2 >= {1'b0, dvs_q};
    r2  = ge2 ? DVS_W'(t2 - {1'b0, dvs_q}) : DVS_W'(t2);
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= P_W'(dividend_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[P_W-3:0], ge1, ge2};
      rem_q <= r2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ITER);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

endmodule

>>> hw/rtl/masked_3x3_convolution_core.sv
// Masked 3x3 convolution core: column stream in, up to two filtered pixels out.
// Per result, the core runs a nine-tap pass of the shared MAC and, in mean mode,
// the radix-4 divider; a no-data centre needs neither. Any output stall holds the
// core. tready stays low for the whole item. Reset (async, active low) restores
// the default kernel and absolute mode and empties the column window. Uses
// m3c_pkg, m3c_mac, m3c_div.
module masked_3x3_convolution_core #(
  parameter int SAMPLE_BITS          = m3c_pkg::SAMPLE_BITS_DEF,
  parameter int WEIGHT_FRACTION_BITS = m3c_pkg::WGT_FRAC_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  // top_sample, top_valid, middle_sample, middle_valid, bottom_sample,
  // bottom_valid, zero fill
  input  logic [((3*(SAMPLE_BITS+1)+7)/8)*8-1:0]       s_axis_tdata,
  input  logic                                         s_axis_tlast,   // row_end
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  output logic [m3c_pkg::OUT_W-1:0]                    m_axis_tdata,   // filtered_value
  output logic [1:0]                                   m_axis_tuser,   // pixel_status
  output logic                                         m_axis_tlast,   // last_of_run
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  input  logic                                         cfg_we_i,
  input  logic [m3c_pkg::CFG_IDX_W-1:0]                cfg_idx_i,
  input  logic [m3c_pkg::CFG_DATA_W-1:0]               cfg_data_i
);

  localparam int S      = SAMPLE_BITS;
  localparam int F      = WEIGHT_FRACTION_BITS;
  localparam int OW     = m3c_pkg::OUT_W;
  localparam int DW     = m3c_pkg::DEN_W;
  localparam int WW     = m3c_pkg::WGT_W;
  localparam int ACC_W  = S + WW + 4;
  localparam int DVD_W  = ACC_W + F;
  localparam int Q_W    = 2 * ((DVD_W + 1) / 2);
  localparam int MAG_W  = (Q_W > OW + 1) ? Q_W : OW + 1;
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(1) << (OW - 1);
  localparam logic [MAG_W-1:0] POS_LIM = NEG_LIM - MAG_W'(1);
  localparam logic [1:0] TAP_LAST = 2'(m3c_pkg::KERNEL_SIZE - 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SETUP  = 7'b0000010,
    ST_MAC    = 7'b0000100,
    ST_DRAIN  = 7'b0001000,
    ST_DECIDE = 7'b0010000,
    ST_DIV    = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_e;

  // Column sources of the window
  typedef enum logic [1:0] {
    SRC_WIN0 = 2'd0,
    SRC_WIN1 = 2'd1,
    SRC_CUR  = 2'd2,
    SRC_NONE = 2'd3
  } col_src_e;

  state_e state_q, state_d;

  // configuration
  logic [m3c_pkg::KROW_W-1:0] krow_q [m3c_pkg::KERNEL_SIZE];
  logic                       abs_q;

  // column window and current column
  logic signed [S-1:0] win_smp_q [2][3];
  logic [2:0]          win_vld_q [2];
  logic [1:0]          held_q;
  logic signed [S-1:0] cur_smp_q [3];
  logic [2:0]          cur_vld_q;
  logic                row_end_q;

  // sequencing
  logic       pass_q, pass_d;
  logic [1:0] col_q, col_d, row_q, row_d;
  logic       finish;

  // result
  logic [OW-1:0] res_val_q, res_val_d;
  logic [1:0]    res_st_q, res_st_d;

  // output register
  logic          out_vld_q;
  logic [OW-1:0] out_val_q;
  logic [1:0]    out_st_q;
  logic          out_last_q;
  logic          out_free, out_load;

  // datapath
  m3c_pkg::mac_ctl_t           mac_ctl;
  logic signed [S-1:0]         tap_smp;
  logic                        tap_vld;
  logic signed [WW-1:0]        tap_wgt;
  logic signed [ACC_W-1:0]     num;
  logic signed [DW-1:0]        den;
  logic                        num_neg, den_neg;
  logic [ACC_W-1:0]            num_mag;
  logic [DW-1:0]               den_mag;
  logic                        div_start, div_done;
  logic [Q_W-1:0]              quot;
  logic [MAG_W-1:0]            mag_sel, mag_c;
  logic                        neg_sel;
  logic [OW-1:0]               clamp_val;
  col_src_e                    tap_src;
  logic [1:0]                  ctr_vld;
  logic [m3c_pkg::KROW_W-1:0]  wrow;

  logic s_acc;
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      krow_q[0] <= m3c_pkg::KROW_OUTER_RST;
      krow_q[1] <= m3c_pkg::KROW_MIDDLE_RST;
      krow_q[2] <= m3c_pkg::KROW_OUTER_RST;
      abs_q     <= m3c_pkg::ABS_MODE_RST;
    end else if (cfg_we_i) begin
      unique case (m3c_pkg::cfg_reg_e'(cfg_idx_i))
        m3c_pkg::CFG_KTOP: krow_q[0] <= cfg_data_i;
        m3c_pkg::CFG_KMID: krow_q[1] <= cfg_data_i;
        m3c_pkg::CFG_KBOT: krow_q[2] <= cfg_data_i;
        m3c_pkg::CFG_ABS:  abs_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // capture the incoming column
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      cur_smp_q[0] <= s_axis_tdata[S-1:0];
      cur_smp_q[1] <= s_axis_tdata[2*S:S+1];
      cur_smp_q[2] <= s_axis_tdata[3*S+1:2*S+2];
      row_end_q    <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= '0;
    end else if (s_acc) begin
      cur_vld_q <= {s_axis_tdata[3*S+2], s_axis_tdata[2*S+1], s_axis_tdata[S]};
    end
  end

  // window: shift on a plain column, drop everything at the end of a row
  always_ff @(posedge clk_i) begin
    if (finish && !row_end_q) begin
      for (int r = 0; r < 3; r++) begin
        win_smp_q[0][r] <= win_smp_q[1][r];
        win_smp_q[1][r] <= cur_smp_q[r];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_vld_q[0] <= '0;
      win_vld_q[1] <= '0;
      held_q       <= '0;
    end else if (finish) begin
      if (row_end_q) begin
        win_vld_q[0] <= '0;
        win_vld_q[1] <= '0;
        held_q       <= '0;
      end else begin
        win_vld_q[0] <= win_vld_q[1];
        win_vld_q[1] <= cur_vld_q;
        if (!held_q[1]) held_q <= held_q + 2'd1;
      end
    end
  end

  // tap selection: pass 0 centres on the held column, pass 1 on the new one
  assign tap_src = col_src_e'(col_q + {1'b0, pass_q});

  always_comb begin
    tap_smp = '0;
    tap_vld = 1'b0;
    unique case (tap_src)
      SRC_WIN0: begin
        tap_smp = win_smp_q[0][row_q];
        tap_vld = win_vld_q[0][row_q] & held_q[1];
      end
      SRC_WIN1: begin
        tap_smp = win_smp_q[1][row_q];
        tap_vld = win_vld_q[1][row_q] & (held_q != 2'd0);
      end
      SRC_CUR: begin
        tap_smp = cur_smp_q[row_q];
        tap_vld = cur_vld_q[row_q];
      end
      SRC_NONE: begin
        tap_smp = '0;
        tap_vld = 1'b0;
      end
      default: ;
    endcase
  end

  assign ctr_vld = {cur_vld_q[1], win_vld_q[1][1]};

  always_comb begin
    wrow    = krow_q[row_q];
    tap_wgt = '0;
    unique case (col_q)
      2'd0:    tap_wgt = wrow[3*WW-1:2*WW];
      2'd1:    tap_wgt = wrow[2*WW-1:WW];
      2'd2:    tap_wgt = wrow[WW-1:0];
      default: tap_wgt = '0;
    endcase
  end

  m3c_mac #(
    .SAMPLE_BITS (S),
    .ACC_W       (ACC_W)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .sample_i (tap_smp),
    .weight_i (tap_wgt),
    .num_o    (num),
    .den_o    (den)
  );

  assign num_neg = num[ACC_W-1];
  assign den_neg = den[DW-1];
  assign num_mag = num_neg ? (~num + ACC_W'(1)) : num;
  assign den_mag = den_neg ? (~den + DW'(1)) : den;

  m3c_div #(
    .DVD_W (DVD_W),
    .DVS_W (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({num_mag, {F{1'b0}}}),
    .divisor_i  (den_mag),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // saturate sign and magnitude to the output range
  always_comb begin
    mag_sel = abs_q ? MAG_W'(num_mag) : MAG_W'(quot);
    neg_sel = abs_q ? num_neg : (num_neg ^ den_neg);
    if (neg_sel) begin
      mag_c     = (mag_sel > NEG_LIM) ? NEG_LIM : mag_sel;
      clamp_val = OW'(MAG_W'(0) - mag_c);
    end else begin
      mag_c     = (mag_sel > POS_LIM) ? POS_LIM : mag_sel;
      clamp_val = OW'(mag_c);
    end
  end

  assign out_free = !out_vld_q || m_axis_tready;

  // sequencer
  always_comb begin
    state_d   = state_q;
    pass_d    = pass_q;
    col_d     = col_q;
    row_d     = row_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    mac_ctl   = '0;
    div_start = 1'b0;
    finish    = 1'b0;
    out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          pass_d  = 1'b0;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (!pass_q && held_q == 2'd0) begin
          pass_d = 1'b1;
        end else if (pass_q && !row_end_q) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end else if (!ctr_vld[pass_q]) begin
          res_val_d = '0;
          res_st_d  = m3c_pkg::PIX_NODATA;
          state_d   = ST_EMIT;
        end else begin
          mac_ctl.clr = 1'b1;
          col_d       = '0;
          row_d       = '0;
          state_d     = ST_MAC;
        end
      end
      ST_MAC: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.vld = tap_vld;
        if (row_q == TAP_LAST) begin
          row_d = '0;
          if (col_q == TAP_LAST) begin
            state_d = ST_DRAIN;
          end else begin
            col_d = col_q + 2'd1;
          end
        end else begin
          row_d = row_q + 2'd1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (abs_q) begin
          res_val_d = clamp_val;
          res_st_d  = m3c_pkg::PIX_VALID;
          state_d   = ST_EMIT;
        end else if (den == '0) begin
          res_val_d = '0;
          res_st_d  = m3c_pkg::PIX_ZERO_WSUM;
          state_d   = ST_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_val_d = clamp_val;
          res_st_d  = m3c_pkg::PIX_VALID;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!pass_q) begin
            pass_d  = 1'b1;
            state_d = ST_SETUP;
          end else begin
            finish  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
  end

  // output register: holds a request until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q  <= res_val_q;
      out_st_q   <= res_st_q;
      out_last_q <= pass_q | ~row_end_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tlast  = out_last_q;

endmodule
